// ----- design/spr_pkg.sv -----
`timescale 1ns / 1ps
// Package: shared types, constants and helpers for the stream pattern replace core.
package spr_pkg;

  localparam int PAT_BYTES_DEF = 16;
  localparam int VAL_BYTES_DEF = 16;
  localparam int LEN_W         = 5;
  localparam int ADDR_W        = 6;
  localparam int DATA_W        = 64;
  localparam int IDX_W         = 3;

  typedef logic [IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_PATTERN_LOW    = 3'd0;
  localparam reg_idx_t REG_PATTERN_HIGH   = 3'd1;
  localparam reg_idx_t REG_PATTERN_LENGTH = 3'd2;
  localparam reg_idx_t REG_VALUE_LOW      = 3'd3;
  localparam reg_idx_t REG_VALUE_HIGH     = 3'd4;
  localparam reg_idx_t REG_VALUE_LENGTH   = 3'd5;

  typedef struct packed {
    logic             active;
    logic             shift;
    logic [7:0]       data;
    logic [LEN_W-1:0] fill;
    logic [LEN_W-1:0] plen;
  } win_ctl_t;

  typedef struct packed {
    logic load;
    logic shift;
  } out_ctl_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [DATA_W-1:0] v,
                                                 input logic [LEN_W-1:0] maxv);
    logic [LEN_W-1:0] x;
    x = v[LEN_W-1:0];
    if (x == '0) begin
      return LEN_W'(1);
    end else if (x > maxv) begin
      return maxv;
    end
    return x;
  endfunction

endpackage

// ----- design/stream_pattern_replace_core.sv -----
`timescale 1ns / 1ps
// Top level: streaming find and replace over a row of window and playout cells.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  in       | in_valid / in_stall        | in_byte, in_end_of_stream
//  out      | out_valid / out_stall      | out_byte, out_last_of_run
//  config   | psel, penable, pwrite, ... | paddr (8*index), pwdata, prdata
//
//  One input request enters per cycle unless in_stall holds it; each yields zero
//  or more bytes and holds the input while the playout row drains one byte per
//  cycle, unless out_stall holds it; the row takes the next run only as its last
//  byte leaves. A one-entry input stage takes a request while the row waits.
//  rst_n is synchronous; it empties the window, playout row and input stage.
//  Stalls on out back up through the playout row into in_stall.
module stream_pattern_replace_core #(
  parameter int MAX_PATTERN_BYTES = spr_pkg::PAT_BYTES_DEF,
  parameter int MAX_VALUE_BYTES   = spr_pkg::VAL_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_byte,
  input  logic                       in_end_of_stream,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_byte,
  output logic                       out_last_of_run,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spr_pkg::ADDR_W-1:0] paddr,
  input  logic [spr_pkg::DATA_W-1:0] pwdata,
  output logic [spr_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import spr_pkg::*;

  localparam int RUN_DEPTH = (MAX_PATTERN_BYTES > MAX_VALUE_BYTES) ?
                             MAX_PATTERN_BYTES : MAX_VALUE_BYTES;
  localparam logic [LEN_W-1:0] PAT_MAX = LEN_W'(MAX_PATTERN_BYTES);
  localparam logic [LEN_W-1:0] VAL_MAX = LEN_W'(MAX_VALUE_BYTES);
  localparam logic [LEN_W-1:0] RUN_MAX = LEN_W'(RUN_DEPTH);

  logic [DATA_W-1:0] pat_low_r, pat_high_r, val_low_r, val_high_r;
  logic [LEN_W-1:0]  plen_r, vlen_r;
  logic [LEN_W-1:0]  fill_r, fill_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic              stage_valid_r, stage_valid_nxt;
  logic [7:0]        stage_byte_r;
  logic              stage_eos_r;

  logic              cfg_wr;
  reg_idx_t          cfg_idx;
  logic              room, go, accept_in, out_acc;
  logic              full, hit;
  logic [LEN_W-1:0]  run_len;
  logic [2*DATA_W-1:0] pat_word, val_word;

  win_ctl_t          win_ctl;
  out_ctl_t          out_ctl;
  logic [7:0]        win_cur   [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] win_match;
  logic [7:0]        run_byte  [RUN_DEPTH];
  logic [7:0]        load_byte [RUN_DEPTH];

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign cfg_idx  = paddr[ADDR_W-1:ADDR_W-IDX_W];
  assign pat_word = {pat_high_r, pat_low_r};
  assign val_word = {val_high_r, val_low_r};

  always_comb begin
    case (cfg_idx)
      REG_PATTERN_LOW:    prdata = pat_low_r;
      REG_PATTERN_HIGH:   prdata = pat_high_r;
      REG_PATTERN_LENGTH: prdata = DATA_W'(plen_r);
      REG_VALUE_LOW:      prdata = val_low_r;
      REG_VALUE_HIGH:     prdata = val_high_r;
      REG_VALUE_LENGTH:   prdata = DATA_W'(vlen_r);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      val_low_r  <= '0;
      val_high_r <= '0;
      plen_r     <= LEN_W'(1);
      vlen_r     <= LEN_W'(1);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PATTERN_LOW:    pat_low_r  <= pwdata;
        REG_PATTERN_HIGH:   pat_high_r <= pwdata;
        REG_PATTERN_LENGTH: plen_r     <= clamp_len(pwdata, PAT_MAX);
        REG_VALUE_LOW:      val_low_r  <= pwdata;
        REG_VALUE_HIGH:     val_high_r <= pwdata;
        REG_VALUE_LENGTH:   vlen_r     <= clamp_len(pwdata, VAL_MAX);
        default:            ;
      endcase
    end
  end

  assign room      = (cnt_r == '0) || ((cnt_r == LEN_W'(1)) && !out_stall);
  assign go        = stage_valid_r && room;
  assign in_stall  = stage_valid_r && !room;
  assign accept_in = in_valid && !in_stall;
  assign out_acc   = (cnt_r != '0) && !out_stall;

  assign full = (LEN_W'(fill_r + LEN_W'(1)) == plen_r);
  assign hit  = full && (&win_match);

  always_comb begin
    if (hit) begin
      run_len = vlen_r;
    end else if (full) begin
      run_len = stage_eos_r ? plen_r : LEN_W'(1);
    end else begin
      run_len = stage_eos_r ? LEN_W'(fill_r + LEN_W'(1)) : '0;
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (cfg_wr && (cfg_idx == REG_PATTERN_LENGTH)) begin
      fill_nxt = '0;
    end else if (go) begin
      if (hit || stage_eos_r) begin
        fill_nxt = '0;
      end else if (full) begin
        fill_nxt = LEN_W'(plen_r - LEN_W'(1));
      end else begin
        fill_nxt = LEN_W'(fill_r + LEN_W'(1));
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (go) begin
      cnt_nxt = run_len;
    end else if (out_acc) begin
      cnt_nxt = LEN_W'(cnt_r - LEN_W'(1));
    end
  end

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (accept_in) begin
      stage_valid_nxt = 1'b1;
    end else if (go) begin
      stage_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r        <= '0;
      cnt_r         <= '0;
      stage_valid_r <= 1'b0;
    end else begin
      fill_r        <= fill_nxt;
      cnt_r         <= cnt_nxt;
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      stage_byte_r <= in_byte;
      stage_eos_r  <= in_end_of_stream;
    end
  end

  assign win_ctl.active = go;
  assign win_ctl.shift  = go && full && !hit && !stage_eos_r;
  assign win_ctl.data   = stage_byte_r;
  assign win_ctl.fill   = fill_r;
  assign win_ctl.plen   = plen_r;

  for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_win
    logic [7:0] next_cur;
    if (i == MAX_PATTERN_BYTES - 1) begin : g_tail
      assign next_cur = 8'h00;
    end else begin : g_body
      assign next_cur = win_cur[i+1];
    end
    spr_win_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .ctl      (win_ctl),
      .pat_byte (pat_word[8*i +: 8]),
      .next_cur (next_cur),
      .cur      (win_cur[i]),
      .match    (win_match[i])
    );
  end

  assign out_ctl.load  = go;
  assign out_ctl.shift = out_acc && !go;

  for (genvar i = 0; i < RUN_DEPTH; i++) begin : g_out
    logic [7:0] vbyte;
    logic [7:0] wbyte;
    logic [7:0] next_byte;
    if (i < MAX_VALUE_BYTES) begin : g_val
      assign vbyte = val_word[8*i +: 8];
    end else begin : g_noval
      assign vbyte = 8'h00;
    end
    if (i < MAX_PATTERN_BYTES) begin : g_wn
      assign wbyte = win_cur[i];
    end else begin : g_nown
      assign wbyte = 8'h00;
    end
    if (i == RUN_DEPTH - 1) begin : g_tail
      assign next_byte = 8'h00;
    end else begin : g_body
      assign next_byte = run_byte[i+1];
    end
    assign load_byte[i] = hit ? vbyte : wbyte;
    spr_out_cell u_cell (
      .clk       (clk),
      .ctl       (out_ctl),
      .load_byte (load_byte[i]),
      .next_byte (next_byte),
      .byte_q    (run_byte[i])
    );
  end

  assign out_valid       = (cnt_r != '0);
  assign out_byte        = run_byte[0];
  assign out_last_of_run = (cnt_r == LEN_W'(1));

  a_fill_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < plen_r) else $error("window fill reached pattern length");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= RUN_MAX) else $error("playout count above row depth");

  a_hit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    go && hit |=> fill_r == '0) else $error("window not emptied after match");

  a_held_stage: assert property (@(posedge clk) disable iff (!rst_n)
    stage_valid_r && !room |=> stage_valid_r) else $error("stage dropped a request");

endmodule

// ----- design/spr_win_cell.sv -----
`timescale 1ns / 1ps
// Window cell: holds one window byte and compares it against its pattern byte.
module spr_win_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  spr_pkg::win_ctl_t ctl,
  input  logic [7:0]        pat_byte,
  input  logic [7:0]        next_cur,
  output logic [7:0]        cur,
  output logic              match
);
  import spr_pkg::*;

  localparam logic [LEN_W-1:0] MY_IDX = LEN_W'(IDX);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;
  logic       here;

  assign here  = ctl.active && (ctl.fill == MY_IDX);
  assign cur   = here ? ctl.data : byte_r;
  assign match = (cur == pat_byte) || (MY_IDX >= ctl.plen);

  always_comb begin
    byte_nxt = byte_r;
    if (ctl.shift) begin
      byte_nxt = next_cur;
    end else if (here) begin
      byte_nxt = ctl.data;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

endmodule

// ----- design/spr_out_cell.sv -----
`timescale 1ns / 1ps
// Playout cell: holds one pending output byte and hands it toward the output.
module spr_out_cell (
  input  logic              clk,
  input  spr_pkg::out_ctl_t ctl,
  input  logic [7:0]        load_byte,
  input  logic [7:0]        next_byte,
  output logic [7:0]        byte_q
);
  import spr_pkg::*;

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctl.load) begin
      byte_nxt = load_byte;
    end else if (ctl.shift) begin
      byte_nxt = next_byte;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_q = byte_r;

endmodule

// ----- verif/tb_stream_pattern_replace_core.sv -----
`timescale 1ns / 1ps
// Testbench: self-checking stimulus and byte-level scoreboard for stream_pattern_replace_core.
module tb_stream_pattern_replace_core;
  import spr_pkg::*;

  localparam int WIN_DEPTH   = 16;
  localparam int NUM_PHASES  = 9;
  localparam int PHASE_ITEMS = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 20;
  localparam int CYCLE_LIMIT = 400000;

  localparam reg_idx_t REG_SPARE_LO = 3'd6;
  localparam reg_idx_t REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  class replace_tracker;
    logic [63:0] pat_lo, pat_hi, val_lo, val_hi;
    int          pat_len, val_len;
    logic [7:0]  window [WIN_DEPTH];
    int          fill;
    out_beat_t   expected_beats [$];
    int          errors;

    function new();
      pat_lo  = '0;
      pat_hi  = '0;
      val_lo  = '0;
      val_hi  = '0;
      pat_len = 1;
      val_len = 1;
      fill    = 0;
      errors  = 0;
      foreach (window[i]) window[i] = '0;
    endfunction

    function int fit_len(logic [63:0] v, int maxv);
      int x;
      x = int'(v[LEN_W-1:0]);
      if (x == 0) return 1;
      if (x > maxv) return maxv;
      return x;
    endfunction

    function logic [7:0] byte_at(logic [63:0] lo, logic [63:0] hi, int k);
      if (k < 8) return lo[8*k +: 8];
      return hi[8*(k-8) +: 8];
    endfunction

    function void write_reg(reg_idx_t idx, logic [63:0] v);
      case (idx)
        REG_PATTERN_LOW:    pat_lo = v;
        REG_PATTERN_HIGH:   pat_hi = v;
        REG_PATTERN_LENGTH: begin
          pat_len = fit_len(v, WIN_DEPTH);
          fill    = 0;
        end
        REG_VALUE_LOW:      val_lo = v;
        REG_VALUE_HIGH:     val_hi = v;
        REG_VALUE_LENGTH:   val_len = fit_len(v, WIN_DEPTH);
        default: ;
      endcase
    endfunction

    function void note_request(logic [7:0] b, logic eos);
      logic [7:0] run [$];
      bit         hit;
      out_beat_t  beat;
      if (fill >= pat_len) fill = 0;
      window[fill] = b;
      fill++;
      if (fill == pat_len) begin
        hit = 1'b1;
        for (int i = 0; i < pat_len; i++) begin
          if (window[i] != byte_at(pat_lo, pat_hi, i)) hit = 1'b0;
        end
        if (hit) begin
          for (int i = 0; i < val_len; i++) run.push_back(byte_at(val_lo, val_hi, i));
          fill = 0;
        end else begin
          run.push_back(window[0]);
          for (int i = 1; i < fill; i++) window[i-1] = window[i];
          fill--;
        end
      end
      if (eos) begin
        for (int i = 0; i < fill; i++) run.push_back(window[i]);
        fill = 0;
      end
      foreach (run[i]) begin
        beat.data = run[i];
        beat.last = (i == run.size() - 1);
        expected_beats.push_back(beat);
      end
    endfunction

    function void check_result(logic [7:0] data, logic last);
      out_beat_t want;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected output byte %02h last %0b", $time, data, last);
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      if (data !== want.data) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, want.data, data);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: out_last_of_run expected %0b actual %0b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_byte;
  logic              in_end_of_stream;
  logic              out_valid;
  logic              out_stall;
  logic [7:0]        out_byte;
  logic              out_last_of_run;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  replace_tracker sb;
  logic [7:0]     stream_q [$];
  int             send_idle_pct;
  int             recv_idle_pct;
  int             hold_requests;
  int             hold_served;
  int             plen_plan [NUM_PHASES] = '{2, 16, 1, 3, 16, 5, 1, 4, 12};
  int             vlen_plan [NUM_PHASES] = '{1, 16, 3, 16, 1, 2, 16, 7, 5};

  stream_pattern_replace_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last_of_run  (out_last_of_run),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    int left;
    left        = 0;
    hold_served = 0;
    out_stall   = 1'b0;
    forever begin
      @(negedge clk);
      if (left > 0) begin
        out_stall <= 1'b1;
        left--;
      end else if (hold_served != hold_requests) begin
        hold_served++;
        left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_byte, out_last_of_run);
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL stream_pattern_replace_core");
    $finish;
  end

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, v);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_len(input reg_idx_t idx, input logic [4:0] len);
    logic [63:0] v;
    v      = {$urandom, $urandom};
    v[4:0] = len;
    write_reg(idx, v);
  endtask

  task automatic send_request(input logic [7:0] b, input logic eos);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_byte          <= b;
    in_end_of_stream <= eos;
    do @(posedge clk); while (in_stall);
    sb.note_request(b, eos);
  endtask

  task automatic drain_outputs();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_beats.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    drain_outputs();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_stream(input bit pause_mid);
    int n;
    n = stream_q.size();
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) drain_outputs();
      send_request(stream_q[i], i == n - 1);
    end
  endtask

  task automatic build_stream();
    int tokens, plen, r, cut;
    stream_q.delete();
    plen   = sb.pat_len;
    tokens = $urandom_range(3, 24);
    while (tokens > 0 && stream_q.size() < PHASE_ITEMS) begin
      r = $urandom_range(99);
      if (r < 40) begin
        for (int k = 0; k < plen; k++) stream_q.push_back(sb.byte_at(sb.pat_lo, sb.pat_hi, k));
      end else if (r < 55) begin
        cut = $urandom_range(0, plen - 1);
        for (int k = 0; k < cut; k++) stream_q.push_back(sb.byte_at(sb.pat_lo, sb.pat_hi, k));
        stream_q.push_back(8'($urandom_range(255)));
      end else if (r < 85) begin
        stream_q.push_back(sb.byte_at(sb.pat_lo, sb.pat_hi, $urandom_range(plen - 1)));
      end else begin
        stream_q.push_back(8'($urandom_range(255)));
      end
      tokens--;
    end
  endtask

  initial begin
    int sent;
    sb               = new();
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_byte          = '0;
    in_end_of_stream = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    send_idle_pct    = 12;
    recv_idle_pct    = 48;
    hold_requests    = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    stream_q = '{8'h00, 8'hFF};
    send_stream(1'b0);
    wait_idle();

    write_reg(REG_PATTERN_LOW, {$urandom, 8'($urandom), 24'h636261});
    write_reg(REG_PATTERN_HIGH, {$urandom, $urandom});
    write_len(REG_PATTERN_LENGTH, 5'd3);
    write_reg(REG_VALUE_LOW, {$urandom, 16'($urandom), 16'h5958});
    write_reg(REG_VALUE_HIGH, {$urandom, $urandom});
    write_len(REG_VALUE_LENGTH, 5'd2);
    write_reg(REG_SPARE_LO, {$urandom, $urandom});
    write_reg(REG_SPARE_HI, {$urandom, $urandom});
    stream_q = '{8'h78, 8'h61, 8'h62, 8'h63, 8'h61, 8'h62};
    send_stream(1'b0);
    wait_idle();

    write_len(REG_PATTERN_LENGTH, 5'd0);
    write_len(REG_VALUE_LENGTH, 5'd0);
    stream_q = '{sb.byte_at(sb.pat_lo, sb.pat_hi, 0)};
    send_stream(1'b0);
    wait_idle();

    write_reg(REG_PATTERN_LOW, {$urandom, $urandom});
    write_reg(REG_PATTERN_HIGH, {$urandom, $urandom});
    write_len(REG_PATTERN_LENGTH, 5'd31);
    write_reg(REG_VALUE_LOW, {$urandom, $urandom});
    write_reg(REG_VALUE_HIGH, {$urandom, $urandom});
    write_len(REG_VALUE_LENGTH, 5'd17);
    stream_q.delete();
    for (int k = 0; k < WIN_DEPTH; k++) stream_q.push_back(sb.byte_at(sb.pat_lo, sb.pat_hi, k));
    send_stream(1'b0);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 3) begin
        send_idle_pct = 12;
        recv_idle_pct = 48;
      end else if (p < 6) begin
        send_idle_pct = 48;
        recv_idle_pct = 12;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(REG_PATTERN_LOW, {$urandom, $urandom});
      write_reg(REG_PATTERN_HIGH, {$urandom, $urandom});
      write_len(REG_PATTERN_LENGTH, 5'(plen_plan[p]));
      write_reg(REG_VALUE_LOW, {$urandom, $urandom});
      write_reg(REG_VALUE_HIGH, {$urandom, $urandom});
      write_len(REG_VALUE_LENGTH, 5'(vlen_plan[p]));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_stream();
        if (p == 1 && sent == 0) hold_requests++;
        send_stream(p == 2 && sent == 0);
        sent += stream_q.size();
      end
      wait_idle();
    end

    if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
      $display("PASS stream_pattern_replace_core");
    end else begin
      $display("FAIL stream_pattern_replace_core");
    end
    $finish;
  end

endmodule
